// ===== rtl/premultiplied_alpha_over_blend_defines.svh =====
// assertion macros for the verification of the alpha over blend
// no dependencies; included by the checker module
`ifndef PREMULTIPLIED_ALPHA_OVER_BLEND_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_OVER_BLEND_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define POB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define POB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that is also checked across reset
`define POB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pob_pkg.sv =====
// shared types, constants and the divide-by-255 helper for the alpha over blend
// no dependencies; used by every module of the block
package pob_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] prod_t;

  localparam chan_t CH_MAX     = 8'd255;
  localparam prod_t ROUND_BIAS = 16'd127;
  localparam int    NUM_CH     = 4;
  localparam int    ALPHA_CH   = 3;

  // input transfer: premultiplied source and destination pixels
  typedef struct packed {
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
    chan_t dst_red;
    chan_t dst_green;
    chan_t dst_blue;
    chan_t dst_alpha;
  } pob_in_t;

  // result transfer: blended pixel and overwrite flag
  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
    logic  changed;
  } pob_out_t;

  // scaled source handed from the scale half to the blend half
  typedef struct packed {
    chan_t [NUM_CH-1:0] src;
    chan_t [NUM_CH-1:0] dst;
    chan_t              inv;
    logic               sa_zero;
  } pob_scaled_t;

  // floor(v / 255) for v below 65280 via (v + 1 + (v >> 8)) >> 8
  function automatic chan_t div255(input prod_t v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== rtl/pob_scale.sv =====
// source opacity scaling: multiply stage then divide-by-255 stage
// depends on pob_pkg
module pob_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pob_pkg::pob_in_t     up_pix,
  input  pob_pkg::chan_t       opacity,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pob_pkg::pob_scaled_t dn_data
);
  import pob_pkg::*;

  chan_t [NUM_CH-1:0] src_in;
  chan_t [NUM_CH-1:0] dst_in;

  logic               v1_r;
  prod_t [NUM_CH-1:0] prod1_r;
  prod_t [NUM_CH-1:0] prod1_nxt;
  chan_t [NUM_CH-1:0] dst1_r;

  logic               v2_r;
  pob_scaled_t        data2_r;
  pob_scaled_t        data2_nxt;
  logic               s2_ready;

  // unpack the input transfer into channel arrays
  assign src_in = {up_pix.src_alpha, up_pix.src_blue, up_pix.src_green, up_pix.src_red};
  assign dst_in = {up_pix.dst_alpha, up_pix.dst_blue, up_pix.dst_green, up_pix.dst_red};

  // stage ready chain
  assign s2_ready = !v2_r || dn_ready;
  assign up_ready = !v1_r || s2_ready;

  // stage 1: source times opacity plus rounding bias
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod1_nxt[i] = prod_t'(src_in[i]) * prod_t'(opacity) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (up_ready) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod1_r <= prod1_nxt;
      dst1_r  <= dst_in;
    end
  end

  // stage 2: divide by 255, form inverse alpha and the transparent flag
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      data2_nxt.src[i] = div255(prod1_r[i]);
    end
    data2_nxt.dst     = dst1_r;
    data2_nxt.inv     = CH_MAX - data2_nxt.src[ALPHA_CH];
    data2_nxt.sa_zero = (data2_nxt.src[ALPHA_CH] == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && s2_ready) begin
      data2_r <= data2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = data2_r;

endmodule

// ===== rtl/pob_blend.sv =====
// destination weighting and final sum: multiply stage then divide, add, saturate
// depends on pob_pkg
module pob_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pob_pkg::pob_scaled_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pob_pkg::pob_out_t    dn_pix
);
  import pob_pkg::*;

  logic               v3_r;
  prod_t [NUM_CH-1:0] prod3_r;
  prod_t [NUM_CH-1:0] prod3_nxt;
  chan_t [NUM_CH-1:0] src3_r;
  chan_t [NUM_CH-1:0] dst3_r;
  logic               zero3_r;

  logic               v4_r;
  pob_out_t           pix4_r;
  pob_out_t           pix4_nxt;
  chan_t [NUM_CH-1:0] res;
  logic  [8:0]        sum;
  logic               s4_ready;

  // stage ready chain
  assign s4_ready = !v4_r || dn_ready;
  assign up_ready = !v3_r || s4_ready;

  // stage 3: destination times inverse source alpha plus rounding bias
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod3_nxt[i] = prod_t'(up_data.dst[i]) * prod_t'(up_data.inv) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (up_ready) begin
      v3_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod3_r <= prod3_nxt;
      src3_r  <= up_data.src;
      dst3_r  <= up_data.dst;
      zero3_r <= up_data.sa_zero;
    end
  end

  // stage 4: divide by 255, add source, saturate; transparent source passes dst
  always_comb begin
    sum = 9'd0;
    for (int i = 0; i < NUM_CH; i++) begin
      sum    = {1'b0, src3_r[i]} + {1'b0, div255(prod3_r[i])};
      res[i] = sum[8] ? CH_MAX : sum[7:0];
      if (zero3_r) begin
        res[i] = dst3_r[i];
      end
    end
    pix4_nxt.out_red   = res[0];
    pix4_nxt.out_green = res[1];
    pix4_nxt.out_blue  = res[2];
    pix4_nxt.out_alpha = res[3];
    pix4_nxt.changed   = !zero3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (s4_ready) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && s4_ready) begin
      pix4_r <= pix4_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign dn_pix   = pix4_r;

endmodule

// ===== rtl/premultiplied_alpha_over_blend.sv =====
// throughput: one pixel per clock while out_stall is low, set by the four register
//   stages (source multiply, divide by 255, destination multiply,
//   divide/add/saturate), each taking a new pixel
// reset: synchronous active-low rst_n clears all stage valid bits and sets opacity to 255
// top level of the premultiplied alpha over blend; depends on pob_pkg, pob_scale, pob_blend
module premultiplied_alpha_over_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pob_pkg::pob_in_t  in_pix,
  output logic              out_valid,
  input  logic              out_stall,
  output pob_pkg::pob_out_t out_pix,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pob_pkg::chan_t    cfg_data
);
  import pob_pkg::*;

  chan_t       opacity_r;
  logic        in_ready;
  logic        mid_valid;
  logic        mid_ready;
  pob_scaled_t mid_data;

  // opacity register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r <= CH_MAX;
    end else if (cfg_valid && cfg_ready) begin
      opacity_r <= cfg_data;
    end
  end

  // source scaling half
  pob_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pix   (in_pix),
    .opacity  (opacity_r),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  // blend half with output register
  pob_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_pix   (out_pix)
  );

  assign in_stall = !in_ready;

endmodule

// ===== rtl/pob_checker.sv =====
// port-level checks for the premultiplied alpha over blend, bound to the top level
// depends on pob_pkg and premultiplied_alpha_over_blend_defines.svh
`include "premultiplied_alpha_over_blend_defines.svh"

module pob_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pob_pkg::pob_in_t  in_pix,
  input logic              out_valid,
  input logic              out_stall,
  input pob_pkg::pob_out_t out_pix
);

  logic in_xfer;
  logic in_wait;
  logic out_wait;

  // handshake conditions seen at the ports
  assign in_xfer  = in_valid && !in_stall;
  assign in_wait  = in_valid && in_stall;
  assign out_wait = out_valid && out_stall;

  // a stalled input holds its payload
  `POB_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_pix), "input moved")

  // a stalled result holds its payload
  `POB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_pix), "result moved")

  // input only backs up when every stage is full and the output is stalled
  `POB_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_wait, "stall with room")

  // an accepted pixel yields a valid result when out_stall stays low behind it
  `POB_ASSERT_NEXT(a_latency, clk, rst_n, in_xfer ##1 !out_stall [*3], out_valid, "pixel late")

  // reset leaves no result pending
  `POB_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "valid after reset")

endmodule

bind premultiplied_alpha_over_blend pob_checker u_pob_checker (.*);
